### sv/c8core_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_pkg
// shared types, constants and the hex font for the instruction core
// ----------------------------------------------------------------------------
package c8core_pkg;

    localparam int MEM_DEPTH     = 4096;
    localparam int ADDR_W        = 12;
    localparam int SCREEN_W      = 64;
    localparam int SCREEN_H      = 32;
    localparam int ROW_W         = 6;
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = 4;
    localparam int FONT_LEN      = 80;
    localparam logic [ADDR_W-1:0] PROGRAM_START = 12'h200;
    localparam logic [ADDR_W-1:0] FONT_BASE     = 12'h050;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [5:0]  pixel_x;
        logic [4:0]  pixel_y;
    } in_word_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [11:0] index_value;
        logic [15:0] executed_opcode;
        logic [7:0]  flag_value;
        logic        pixel_value;
        logic        unknown_opcode;
    } out_word_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       load_in;     // capture input word
        logic [1:0] mem_rd_sel;  // 0 pc, 1 pc+1, 2 index+row, 3 init sweep
        logic       mem_wr;      // write from input word
        logic       font_wr;     // write one byte of the clear and font sweep
        logic       lat_hi;      // latch high opcode byte
        logic       lat_lo;      // latch low opcode byte
        logic       exec;        // execute non-draw instruction
        logic       draw_start;
        logic       draw_row;    // apply fetched sprite row
        logic       pix_rd;      // read pixel
        logic       clr_step;    // clear one display row
        logic       out_load;    // publish result word
        logic       non_exec;    // result for non-execute item
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       is_draw;
        logic       draw_done;
        logic       is_clear;
        logic       clr_done;
        logic       init_done;
    } stat_t;

    function automatic logic [7:0] font_byte(input logic [6:0] i);
        logic [7:0] f [0:FONT_LEN-1];
        f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        return (i < 7'(FONT_LEN)) ? f[i] : 8'h00;
    endfunction

endpackage

### sv/c8core_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module c8core_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### sv/c8core_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_datapath
// registers, memory, stack, display and instruction execution
// ----------------------------------------------------------------------------
module c8core_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c8core_pkg::in_word_t in_word,
    input  c8core_pkg::cmd_t     cmd,
    output c8core_pkg::stat_t    stat,
    output c8core_pkg::out_word_t out_word
);
    import c8core_pkg::*;

    in_word_t          in_reg;
    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [7:0]        v_reg [0:15];
    logic [ADDR_W-1:0] stk_reg [0:STACK_DEPTH-1];
    logic [SCREEN_W-1:0] fb_reg [0:SCREEN_H-1];
    logic [15:0]       opc_reg;
    logic [3:0]        row_reg;
    logic [4:0]        ycur_reg;
    logic [ROW_W-1:0]  x0_reg;
    logic              draw_act_reg;
    logic [4:0]        clr_reg;
    logic [ADDR_W-1:0] init_reg;
    logic              init_done_reg;
    logic              bad_reg;
    out_word_t         out_reg;

    // memory port
    logic              m_we;
    logic [ADDR_W-1:0] m_addr;
    logic [7:0]        m_wdata, m_rdata;

    // init sweep: zero everywhere, font bytes from FONT_BASE on
    logic [ADDR_W-1:0] font_off;
    assign font_off = init_reg - FONT_BASE;

    always_comb
    begin
        m_we = cmd.mem_wr | cmd.font_wr;
        if (cmd.font_wr)
        begin
            m_wdata = (font_off < ADDR_W'(FONT_LEN)) ? font_byte(font_off[6:0]) : 8'h00;
        end
        else
        begin
            m_wdata = in_reg.mem_data;
        end
        unique case (cmd.mem_rd_sel)
            2'd0: m_addr = pc_reg;
            2'd1: m_addr = pc_reg + 12'd1;
            2'd2: m_addr = idx_reg + ADDR_W'(row_reg);
            default: m_addr = init_reg;
        endcase
        if (cmd.mem_wr)
        begin
            m_addr = in_reg.mem_addr;
        end
    end

    c8core_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
        .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
    );

    // instruction fields
    logic [3:0] f_op, f_x, f_y, f_n;
    logic [7:0] f_nn;
    logic [11:0] f_nnn, pc2;
    assign f_op  = opc_reg[15:12];
    assign f_x   = opc_reg[11:8];
    assign f_y   = opc_reg[7:4];
    assign f_n   = opc_reg[3:0];
    assign f_nn  = opc_reg[7:0];
    assign f_nnn = opc_reg[11:0];
    assign pc2   = pc_reg + 12'd2;

    // sprite row shifted into screen position, right edge clipped
    logic [SCREEN_W+7:0] spr_wide;
    logic [SCREEN_W-1:0] spr_row, cur_row;
    assign spr_wide = {m_rdata, {SCREEN_W{1'b0}}} >> x0_reg;
    assign spr_row  = spr_wide[SCREEN_W+7:8];
    always_comb
    begin
        cur_row = '0;
        for (int i = 0; i < SCREEN_W; i++)
        begin
            cur_row[SCREEN_W-1-i] = fb_reg[ycur_reg][i];
        end
    end

    // bit i of cur_row is column SCREEN_W-1-i; spr_row msb is column 0
    logic hit;
    assign hit = |(spr_row & cur_row);

    always_comb
    begin
        pc_next  = pc_reg;
        idx_next = idx_reg;
        sp_next  = sp_reg;
        if (cmd.exec)
        begin
            pc_next = pc2;
            unique case (f_op)
                4'h0:
                    if (opc_reg == 16'h00EE)
                    begin
                        sp_next = sp_reg - 4'd1;
                        pc_next = stk_reg[sp_reg - 4'd1] + 12'd2;
                    end
                4'h1: pc_next = f_nnn;
                4'h2:
                begin
                    sp_next = sp_reg + 4'd1;
                    pc_next = f_nnn;
                end
                4'h3: if (v_reg[f_x] == f_nn) pc_next = pc_reg + 12'd4;
                4'h4: if (v_reg[f_x] != f_nn) pc_next = pc_reg + 12'd4;
                4'h5: if (v_reg[f_x] == v_reg[f_y]) pc_next = pc_reg + 12'd4;
                4'hA: idx_next = f_nnn;
                default: ;
            endcase
        end
        if (cmd.draw_start)
        begin
            pc_next = pc2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PROGRAM_START;
            idx_reg       <= '0;
            sp_reg        <= '0;
            draw_act_reg  <= 1'b0;
            init_reg      <= '0;
            init_done_reg <= 1'b0;
            clr_reg       <= '0;
            x0_reg        <= '0;
            ycur_reg      <= '0;
            row_reg       <= '0;
            for (int i = 0; i < 16; i++)
            begin
                v_reg[i] <= '0;
            end
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                stk_reg[i] <= '0;
            end
            for (int i = 0; i < SCREEN_H; i++)
            begin
                fb_reg[i] <= '0;
            end
        end
        else
        begin
            pc_reg  <= pc_next;
            idx_reg <= idx_next;
            sp_reg  <= sp_next;
            if (cmd.font_wr)
            begin
                init_reg <= init_reg + 12'd1;
                if (init_reg == 12'(MEM_DEPTH - 1))
                begin
                    init_done_reg <= 1'b1;
                end
            end
            if (cmd.exec)
            begin
                unique case (f_op)
                    4'h2: stk_reg[sp_reg] <= pc_reg;
                    4'h6: v_reg[f_x] <= f_nn;
                    4'h7: v_reg[f_x] <= v_reg[f_x] + f_nn;
                    default: ;
                endcase
            end
            if (cmd.clr_step)
            begin
                fb_reg[clr_reg] <= '0;
                clr_reg <= clr_reg + 5'd1;
            end
            if (cmd.draw_start)
            begin
                x0_reg       <= v_reg[f_x][ROW_W-1:0];
                ycur_reg     <= v_reg[f_y][4:0];
                row_reg      <= '0;
                v_reg[15]    <= '0;
                draw_act_reg <= (f_n != 4'd0);
            end
            if (cmd.draw_row)
            begin
                for (int i = 0; i < SCREEN_W; i++)
                begin
                    fb_reg[ycur_reg][i] <= fb_reg[ycur_reg][i] ^ spr_row[SCREEN_W-1-i];
                end
                if (hit)
                begin
                    v_reg[15] <= 8'd1;
                end
                row_reg  <= row_reg + 4'd1;
                ycur_reg <= ycur_reg + 5'd1;
                if (row_reg + 4'd1 == f_n || ycur_reg == 5'(SCREEN_H - 1))
                begin
                    draw_act_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg  <= in_word;
            bad_reg <= 1'b0;
        end
        if (cmd.lat_hi)
        begin
            opc_reg[15:8] <= m_rdata;
        end
        if (cmd.lat_lo)
        begin
            opc_reg[7:0] <= m_rdata;
        end
        if (cmd.exec)
        begin
            bad_reg <= (f_op == 4'h0) ? (opc_reg != 16'h00E0 && opc_reg != 16'h00EE)
                     : (f_op >= 4'h8 && f_op != 4'hA && f_op != 4'hD);
        end
        if (cmd.out_load)
        begin
            out_reg.program_counter <= pc_reg;
            out_reg.index_value     <= idx_reg;
            out_reg.executed_opcode <= cmd.non_exec ? 16'h0000 : opc_reg;
            out_reg.flag_value      <= v_reg[15];
            out_reg.unknown_opcode  <= cmd.non_exec ? 1'b0 : bad_reg;
            out_reg.pixel_value     <= cmd.pix_rd
                ? fb_reg[in_reg.pixel_y][in_reg.pixel_x] : 1'b0;
        end
    end

    assign out_word       = out_reg;
    assign stat.op        = in_reg.op;
    assign stat.is_draw   = (f_op == 4'hD);
    assign stat.is_clear  = (opc_reg == 16'h00E0);
    assign stat.draw_done = ~draw_act_reg;
    assign stat.clr_done  = (clr_reg == 5'(SCREEN_H - 1));
    assign stat.init_done = init_done_reg;
endmodule

### sv/c8core_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_ctrl
// sequencer for init sweep, load, fetch, execute, clear, draw and pixel read
// ----------------------------------------------------------------------------
module c8core_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  c8core_pkg::stat_t stat,
    output c8core_pkg::cmd_t  cmd
);
    import c8core_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_F1    = 4'd3;
    localparam logic [3:0] S_F2    = 4'd4;
    localparam logic [3:0] S_F3    = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_CLR   = 4'd7;
    localparam logic [3:0] S_DRAW  = 4'd8;
    localparam logic [3:0] S_DRD   = 4'd9;
    localparam logic [3:0] S_DROW  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       nonex_reg, nonex_next;

    assign out_valid = ov_reg;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg & out_stall;
        nonex_next = nonex_reg;
        cmd        = '0;
        cmd.mem_rd_sel = 2'd0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.font_wr    = 1'b1;
                cmd.mem_rd_sel = 2'd3;
                if (stat.init_done) state_next = S_IDLE;
            end
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            S_DISP:
            begin
                nonex_next = (stat.op != OP_EXEC);
                if (stat.op == OP_WRITE)
                begin
                    cmd.mem_wr = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.op == OP_EXEC)
                begin
                    state_next = S_F1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_F1:
            begin
                cmd.mem_rd_sel = 2'd0;
                state_next = S_F2;
            end
            S_F2:
            begin
                cmd.lat_hi     = 1'b1;
                cmd.mem_rd_sel = 2'd1;
                state_next = S_F3;
            end
            S_F3:
            begin
                cmd.lat_lo = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
                if (stat.is_clear) state_next = S_CLR;
                else if (stat.is_draw)
                begin
                    cmd.draw_start = 1'b1;
                    state_next     = S_DRAW;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_DONE;
                end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DRAW:
            begin
                cmd.mem_rd_sel = 2'd2;
                state_next = stat.draw_done ? S_DONE : S_DRD;
            end
            S_DRD:
            begin
                cmd.mem_rd_sel = 2'd2;
                state_next = S_DROW;
            end
            S_DROW:
            begin
                cmd.mem_rd_sel = 2'd2;
                cmd.draw_row   = 1'b1;
                state_next     = S_DRAW;
            end
            S_DONE:
                // hold while the previous result is still stalled
                if (!ov_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    cmd.non_exec = nonex_reg;
                    cmd.pix_rd   = (stat.op == OP_READ);
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            ov_reg    <= 1'b0;
            nonex_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            nonex_reg <= nonex_next;
        end
    end
endmodule

### sv/chip8_instruction_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_core
// chip-8 style core: memory load, single instruction step, pixel read
// ----------------------------------------------------------------------------
// one word in, one result word out, one item at a time. after reset the core
// sweeps all 4096 memory bytes, writing zeros and the hex font at 0x50, and
// takes no word meanwhile. after a word is taken, a memory write, a pixel read
// or the unused op goes through dispatch and then loads the result register;
// an instruction first fetches its opcode with two single-port memory reads,
// then a plain one executes, a clear wipes one display row per cycle, and DXYN
// reads and applies one sprite row at a time, for the rows left after the
// bottom edge clip. the result sits in an output register and the next word is
// taken while it waits; a finished item only holds in its last cycle while the
// previous result is still stalled.
module chip8_instruction_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  c8core_pkg::in_word_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output c8core_pkg::out_word_t out_data
);
    import c8core_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    c8core_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .stat(stat), .cmd(cmd)
    );

    // architectural state and execution
    c8core_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_word(in_data), .cmd(cmd), .stat(stat), .out_word(out_data)
    );
endmodule
